/* src/rwt_pkg.sv */
// Shared types, codes and helpers for the retransmit window table.
// Used by rwt_cell, retransmit_window_table and its checker.
package rwt_pkg;

	localparam int DepthDefault = 16;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_ACK  = 2'd1;
	localparam logic [1:0] CMD_SCAN = 2'd2;

	localparam logic [2:0] KIND_PUSHED   = 3'd0;
	localparam logic [2:0] KIND_OVERFLOW = 3'd1;
	localparam logic [2:0] KIND_DUP      = 3'd2;
	localparam logic [2:0] KIND_ACKED    = 3'd3;
	localparam logic [2:0] KIND_RESEND   = 3'd4;
	localparam logic [2:0] KIND_GAVEUP   = 3'd5;
	localparam logic [2:0] KIND_DONE     = 3'd6;

	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_MAXTRIES = 2'd2;
	localparam logic [1:0] REG_ENABLE   = 2'd3;

	localparam logic [4:0]  CapacityReset = 5'd16;
	localparam logic [15:0] TimeoutReset  = 16'd400;
	localparam logic [7:0]  MaxTriesReset = 8'd25;

	typedef struct packed {
		logic [15:0] seq;
		logic [15:0] handle;
		logic [15:0] length;
		logic [7:0]  tries;
		logic [31:0] sent;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic keep;
		logic write;
	} cell_ctl_t;

	// True when number a is equal to or serially older than target.
	function automatic logic covered(input logic [15:0] a, input logic [15:0] target);
		logic [15:0] d;
		d = target - a;
		return ~d[15];
	endfunction

endpackage

/* src/rwt_cell.sv */
// One table slot of the retransmit window table chain.
// Depends on rwt_pkg for the entry and control types.
module rwt_cell (
	input  logic               clk,
	input  rwt_pkg::cell_ctl_t ctl,
	input  logic               app_sel,
	input  logic               wr_sel,
	input  rwt_pkg::entry_t    nbr,
	input  rwt_pkg::entry_t    head_new,
	input  rwt_pkg::entry_t    wdata,
	output rwt_pkg::entry_t    q
);

	rwt_pkg::entry_t ent_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			ent_q <= (ctl.keep && app_sel) ? head_new : nbr;
		end else if (ctl.write && wr_sel) begin
			ent_q <= wdata;
		end
	end

	assign q = ent_q;

endmodule

/* src/retransmit_window_table.sv */
// Top level of the retransmit window table: sequencer and a chain of rwt_cell slots.
// Depends on rwt_pkg and rwt_cell.
//
// Channel  Direction  Handshake              Payload
// command  in         start && !busy         cmd, seq, buf_handle, buf_length, now_ms
// result   out        res_valid (one cycle)  kind, seq_res, buf_handle_res, buf_length_res,
//                                            tries, count, last
// config   in         cfg_valid && cfg_ready cfg_index, cfg_data
//
// The table head is examined one entry per cycle while the chain rotates by one slot.
// Push checks every live entry for a duplicate before writing; ack and scan walk the table,
// scan with about three more passes per give-up. An overflowing push or a no-op ends in idle.
// Reset clears occupancy and control; slot contents are undefined until pushed.
// Results cannot be stalled; busy stays high until the last result of a transaction.
module retransmit_window_table #(
	parameter int DEPTH = rwt_pkg::DepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] seq,
	input  logic [15:0] buf_handle,
	input  logic [15:0] buf_length,
	input  logic [31:0] now_ms,
	output logic        res_valid,
	output logic [2:0]  kind,
	output logic [15:0] seq_res,
	output logic [15:0] buf_handle_res,
	output logic [15:0] buf_length_res,
	output logic [7:0]  tries,
	output logic [4:0]  count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int NW   = $clog2(DEPTH + 2);
	localparam int CapW = (CW > 5) ? CW : 5;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PUSH  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_ALIGN = 3'd3;
	localparam logic [2:0] S_GCNT  = 3'd4;
	localparam logic [2:0] S_GREM  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]  state_q, nxt_q;
	logic [4:0]  capacity_q;
	logic [15:0] timeout_q;
	logic [7:0]  max_tries_q;
	logic        enable_q;

	logic [1:0]  cmd_q;
	logic [15:0] tgt_q, trig_q, h_q, len_q;
	logic [31:0] now_q;
	logic [CW-1:0] live_q, k_q, step_q, rot_q, m_q, before_q, removed_q, need_q;
	logic [NW-1:0] n_q;
	logic        dup_q;

	logic        res_valid_q, last_q;
	logic [2:0]  kind_q;
	logic [15:0] seq_res_q, h_res_q, len_res_q;
	logic [7:0]  tries_q;
	logic [4:0]  count_q;

	rwt_pkg::entry_t   cell_q [DEPTH];
	rwt_pkg::entry_t   head, head_new, wdata;
	rwt_pkg::cell_ctl_t ctl;
	logic [DEPTH-1:0]  app_sel, wr_sel;
	logic              resend, timed_out, giveup, full, over_budget;
	logic [31:0]       elapsed;
	logic [CapW-1:0]   cap_x, cap_sat;

	assign head      = cell_q[0];
	assign elapsed   = now_q - head.sent;
	assign timed_out = elapsed > {16'd0, timeout_q};
	assign giveup    = head.tries >= max_tries_q;
	assign cap_x     = CapW'(capacity_q);
	assign cap_sat   = (cap_x > CapW'(DEPTH)) ? CapW'(DEPTH) : cap_x;
	assign full      = CapW'(live_q) >= cap_sat;
	assign over_budget = ((NW + 1)'(n_q) + (NW + 1)'(need_q)) > (NW + 1)'(DEPTH);
	assign wdata     = '{seq: tgt_q, handle: h_q, length: len_q, tries: 8'd0, sent: now_q};

	always_comb begin
		ctl    = '0;
		resend = 1'b0;
		unique case (state_q)
			S_PUSH: begin
				if (step_q != live_q) begin
					ctl.shift = 1'b1;
					ctl.keep  = 1'b1;
				end else begin
					ctl.write = ~dup_q;
				end
			end
			S_WALK: begin
				if (k_q != '0) begin
					if (cmd_q == rwt_pkg::CMD_ACK) begin
						ctl.shift = 1'b1;
						ctl.keep  = ~rwt_pkg::covered(head.seq, tgt_q);
					end else if (!timed_out) begin
						ctl.shift = 1'b1;
						ctl.keep  = 1'b1;
					end else if (!giveup && n_q < NW'(DEPTH)) begin
						ctl.shift = 1'b1;
						ctl.keep  = 1'b1;
						resend    = 1'b1;
					end
				end
			end
			S_ALIGN: begin
				ctl.shift = (rot_q != '0);
				ctl.keep  = 1'b1;
			end
			S_GCNT: begin
				ctl.shift = (step_q != live_q);
				ctl.keep  = 1'b1;
			end
			S_GREM: begin
				ctl.shift = (k_q != '0);
				ctl.keep  = ~rwt_pkg::covered(head.seq, trig_q);
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_comb begin
		head_new = head;
		if (resend) begin
			head_new.sent = now_q;
			if (head.tries != 8'hFF) begin
				head_new.tries = head.tries + 8'd1;
			end
		end
	end

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		rwt_pkg::entry_t nbr;
		assign app_sel[j] = (live_q == CW'(j + 1));
		assign wr_sel[j]  = (live_q == CW'(j));
		if (j == DEPTH - 1) begin : g_tail
			assign nbr = head_new;
		end else begin : g_mid
			assign nbr = cell_q[j + 1];
		end
		rwt_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.app_sel  (app_sel[j]),
			.wr_sel   (wr_sel[j]),
			.nbr      (nbr),
			.head_new (head_new),
			.wdata    (wdata),
			.q        (cell_q[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= rwt_pkg::CapacityReset;
			timeout_q   <= rwt_pkg::TimeoutReset;
			max_tries_q <= rwt_pkg::MaxTriesReset;
			enable_q    <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rwt_pkg::REG_CAPACITY: capacity_q  <= cfg_data[4:0];
				rwt_pkg::REG_TIMEOUT:  timeout_q   <= cfg_data[15:0];
				rwt_pkg::REG_MAXTRIES: max_tries_q <= cfg_data[7:0];
				rwt_pkg::REG_ENABLE:   enable_q    <= cfg_data[0];
				default:               enable_q    <= enable_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
			tgt_q <= seq;
			h_q   <= buf_handle;
			len_q <= buf_length;
			now_q <= now_ms;
		end
		if (state_q == S_WALK && k_q != '0 && cmd_q != rwt_pkg::CMD_ACK) begin
			trig_q <= head.seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nxt_q       <= S_IDLE;
			live_q      <= '0;
			k_q         <= '0;
			step_q      <= '0;
			rot_q       <= '0;
			m_q         <= '0;
			before_q    <= '0;
			removed_q   <= '0;
			need_q      <= '0;
			n_q         <= '0;
			dup_q       <= 1'b0;
			res_valid_q <= 1'b0;
			last_q      <= 1'b0;
			kind_q      <= '0;
			seq_res_q   <= '0;
			h_res_q     <= '0;
			len_res_q   <= '0;
			tries_q     <= '0;
			count_q     <= '0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						removed_q <= '0;
						n_q       <= '0;
						k_q       <= live_q;
						if (cmd == rwt_pkg::CMD_PUSH && full) begin
							res_valid_q <= 1'b1;
							kind_q      <= rwt_pkg::KIND_OVERFLOW;
							seq_res_q   <= seq;
							h_res_q     <= buf_handle;
							len_res_q   <= buf_length;
							tries_q     <= '0;
							count_q     <= '0;
							last_q      <= 1'b1;
						end else if (cmd == rwt_pkg::CMD_PUSH) begin
							state_q <= S_PUSH;
							step_q  <= '0;
							dup_q   <= 1'b0;
						end else if (cmd == rwt_pkg::CMD_ACK ||
							(cmd == rwt_pkg::CMD_SCAN && enable_q)) begin
							state_q <= S_WALK;
						end else begin
							res_valid_q <= 1'b1;
							kind_q      <= rwt_pkg::KIND_DONE;
							seq_res_q   <= '0;
							h_res_q     <= '0;
							len_res_q   <= '0;
							tries_q     <= '0;
							count_q     <= '0;
							last_q      <= 1'b1;
						end
					end
				end
				S_PUSH: begin
					if (step_q == live_q) begin
						res_valid_q <= 1'b1;
						kind_q      <= dup_q ? rwt_pkg::KIND_DUP : rwt_pkg::KIND_PUSHED;
						seq_res_q   <= tgt_q;
						h_res_q     <= h_q;
						len_res_q   <= len_q;
						tries_q     <= '0;
						count_q     <= '0;
						last_q      <= 1'b1;
						if (!dup_q) begin
							live_q <= live_q + CW'(1);
						end
						state_q <= S_IDLE;
					end else begin
						dup_q  <= dup_q | (head.seq == tgt_q);
						step_q <= step_q + CW'(1);
					end
				end
				S_WALK: begin
					if (k_q == '0) begin
						state_q <= S_FIN;
					end else if (cmd_q == rwt_pkg::CMD_ACK) begin
						k_q <= k_q - CW'(1);
						if (rwt_pkg::covered(head.seq, tgt_q)) begin
							res_valid_q <= 1'b1;
							kind_q      <= rwt_pkg::KIND_ACKED;
							seq_res_q   <= head.seq;
							h_res_q     <= head.handle;
							len_res_q   <= head.length;
							tries_q     <= head.tries;
							count_q     <= '0;
							last_q      <= 1'b0;
							removed_q   <= removed_q + CW'(1);
							live_q      <= live_q - CW'(1);
						end
					end else if (!timed_out) begin
						k_q <= k_q - CW'(1);
					end else if (giveup) begin
						m_q     <= live_q - k_q;
						rot_q   <= k_q;
						nxt_q   <= S_GCNT;
						state_q <= S_ALIGN;
					end else if (n_q >= NW'(DEPTH)) begin
						rot_q   <= k_q;
						nxt_q   <= S_FIN;
						state_q <= S_ALIGN;
					end else begin
						res_valid_q <= 1'b1;
						kind_q      <= rwt_pkg::KIND_RESEND;
						seq_res_q   <= head.seq;
						h_res_q     <= head.handle;
						len_res_q   <= head.length;
						tries_q     <= head.tries;
						count_q     <= '0;
						last_q      <= 1'b0;
						n_q         <= n_q + NW'(1);
						k_q         <= k_q - CW'(1);
					end
				end
				S_ALIGN: begin
					if (rot_q == '0) begin
						state_q <= nxt_q;
						step_q  <= '0;
						need_q  <= '0;
						k_q     <= live_q - m_q;
					end else begin
						rot_q <= rot_q - CW'(1);
					end
				end
				S_GCNT: begin
					if (step_q == live_q) begin
						if (over_budget) begin
							state_q <= S_FIN;
						end else begin
							state_q  <= S_GREM;
							step_q   <= '0;
							before_q <= '0;
							k_q      <= live_q;
						end
					end else begin
						if (rwt_pkg::covered(head.seq, trig_q)) begin
							need_q <= need_q + CW'(1);
						end
						step_q <= step_q + CW'(1);
					end
				end
				S_GREM: begin
					if (k_q == '0) begin
						m_q     <= m_q - before_q;
						rot_q   <= m_q - before_q;
						nxt_q   <= S_WALK;
						state_q <= S_ALIGN;
					end else begin
						if (rwt_pkg::covered(head.seq, trig_q)) begin
							res_valid_q <= 1'b1;
							kind_q      <= (step_q == m_q) ? rwt_pkg::KIND_GAVEUP
								: rwt_pkg::KIND_ACKED;
							seq_res_q   <= head.seq;
							h_res_q     <= head.handle;
							len_res_q   <= head.length;
							tries_q     <= head.tries;
							count_q     <= '0;
							last_q      <= 1'b0;
							removed_q   <= removed_q + CW'(1);
							live_q      <= live_q - CW'(1);
							n_q         <= n_q + NW'(1);
							if (step_q < m_q) begin
								before_q <= before_q + CW'(1);
							end
						end
						step_q <= step_q + CW'(1);
						k_q    <= k_q - CW'(1);
					end
				end
				S_FIN: begin
					res_valid_q <= 1'b1;
					kind_q      <= rwt_pkg::KIND_DONE;
					seq_res_q   <= '0;
					h_res_q     <= '0;
					len_res_q   <= '0;
					tries_q     <= '0;
					count_q     <= 5'(removed_q);
					last_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign cfg_ready      = 1'b1;
	assign res_valid      = res_valid_q;
	assign kind           = kind_q;
	assign seq_res        = seq_res_q;
	assign buf_handle_res = h_res_q;
	assign buf_length_res = len_res_q;
	assign tries          = tries_q;
	assign count          = count_q;
	assign last           = last_q;

endmodule

/* src/rwt_checker.sv */
// Port-level checks for retransmit_window_table and the bind that attaches them.
// Depends on rwt_pkg for the result codes.
module rwt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       res_valid,
	input logic [2:0] kind,
	input logic       last
);

	a_cmd_response: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || res_valid))
		else $error("Accepted transaction produced neither work nor a result.");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && last) |-> !busy)
		else $error("Block still busy after the final result.");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !last) |-> busy)
		else $error("Intermediate result seen while the block is idle.");

	a_single_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (kind == rwt_pkg::KIND_PUSHED || kind == rwt_pkg::KIND_OVERFLOW
			|| kind == rwt_pkg::KIND_DUP || kind == rwt_pkg::KIND_DONE)) |-> last)
		else $error("Push or done result not marked as final.");

endmodule

bind retransmit_window_table rwt_checker u_rwt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.res_valid (res_valid),
	.kind      (kind),
	.last      (last)
);
